### rtl/dfe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the damped feedback echo.
// No dependencies; used by damped_feedback_echo.
package dfe_pkg;

	localparam int FB_W   = 15;
	localparam int DAMP_W = 16;
	localparam int DIST_W = 13;
	localparam int SMP_W  = 16;
	localparam int FILT_W = 18;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_FEEDBACK = 2'd0;
	localparam logic [1:0] REG_DAMPING  = 2'd1;
	localparam logic [1:0] REG_DISTANCE = 2'd2;

	localparam logic signed [FILT_W-1:0] FILT_MAX = 18'sd131071;
	localparam logic signed [FILT_W-1:0] FILT_MIN = -18'sd131072;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_MUL1  = 7'b0000100,
		ST_SUB   = 7'b0001000,
		ST_MUL2  = 7'b0010000,
		ST_WR    = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

endpackage

### rtl/damped_feedback_echo.sv
`timescale 1ns / 1ps
// Damped feedback echo: delay line, feedback gain and one-pole low-pass.
// Depends on dfe_pkg; the delay line is a memory inside this module.
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+---------------------------
// in      | input     | in_valid / in_ready  | dry_sample, prior_output
// out     | output    | out_valid / out_ready| out_sample
// cfg     | input     | APB psel/penable     | feedback, damping, distance
//
// With echo active, a request runs from acceptance to the next acceptance through
// a memory read, two passes through the shared multiplier, a subtraction, the
// line write and the result hand-off; with feedback zero it goes straight to the
// hand-off. After reset a clearing pass writes mid level to all LINE_DEPTH
// entries, one a cycle; in_ready stays low until that pass ends.
// A stalled result holds in the output register; the sequencer waits in its
// final step until that register is free.
module damped_feedback_echo #(
	parameter int LINE_DEPTH = 4096,
	parameter int FRAC_BITS  = 15,
	parameter int MID_LEVEL  = 32768
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [dfe_pkg::SMP_W-1:0]   dry_sample,
	input  logic [dfe_pkg::SMP_W-1:0]   prior_output,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dfe_pkg::SMP_W-1:0]   out_sample,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dfe_pkg::ADDR_W-1:0]  paddr,
	input  logic [dfe_pkg::DATA_W-1:0]  pwdata,
	output logic [dfe_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int SW = AW + 2;
	localparam logic [AW-1:0] POS_LAST = AW'(LINE_DEPTH - 1);
	localparam logic [SW-1:0] LEN_W = SW'(LINE_DEPTH);
	localparam logic [dfe_pkg::FB_W-1:0] FB_MAX = dfe_pkg::FB_W'((1 << FRAC_BITS) - 1);
	localparam logic [dfe_pkg::DAMP_W-1:0] ONE_Q = dfe_pkg::DAMP_W'(1 << FRAC_BITS);
	localparam logic signed [16:0] MID_S = 17'(MID_LEVEL);
	localparam logic signed [21:0] MID_X = 22'(MID_LEVEL);

	dfe_pkg::state_t state_q;

	logic [dfe_pkg::FB_W-1:0]   feedback_gain_q;
	logic [dfe_pkg::DAMP_W-1:0] damping_amount_q;
	logic [dfe_pkg::DIST_W-1:0] echo_distance_q;

	logic [AW-1:0] pos_q;
	logic [AW-1:0] clr_q;
	logic signed [dfe_pkg::FILT_W-1:0] filt_q;

	logic [dfe_pkg::SMP_W-1:0] mem_q [LINE_DEPTH];
	logic [dfe_pkg::SMP_W-1:0] rdata_q;
	logic [dfe_pkg::SMP_W-1:0] dry_q;
	logic [dfe_pkg::SMP_W-1:0] prior_q;
	logic [dfe_pkg::SMP_W-1:0] result_q;
	logic                      out_valid_q;
	logic signed [20:0]        diff_q;
	logic signed [37:0]        prod_q;

	logic                      cfg_wr;
	logic                      accept;
	logic [dfe_pkg::FB_W-1:0]  fb;
	logic [dfe_pkg::DAMP_W-1:0] coeff;
	logic [SW-1:0]             tap_dist;
	logic [SW-1:0]             rd_sum;
	logic [AW-1:0]             rd_addr;
	logic signed [16:0]        delayed;
	logic signed [17:0]        out_sum;
	logic [dfe_pkg::SMP_W-1:0] out_sat;
	logic signed [37:0]        prod_sh;
	logic signed [19:0]        fb_in;
	logic signed [21:0]        filt_sum;
	logic signed [dfe_pkg::FILT_W-1:0] filt_new;
	logic signed [21:0]        line_sum;
	logic [dfe_pkg::SMP_W-1:0] line_val;
	logic signed [20:0]        mul_a;
	logic signed [16:0]        mul_b;
	logic                      mem_we;
	logic [AW-1:0]             mem_wa;
	logic [dfe_pkg::SMP_W-1:0] mem_wd;
	logic                      done_go;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_ready = (state_q == dfe_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign out_sample = result_q;
	assign done_go  = (state_q == dfe_pkg::ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		unique case (paddr[3:2])
			dfe_pkg::REG_FEEDBACK: prdata = {17'b0, feedback_gain_q};
			dfe_pkg::REG_DAMPING:  prdata = {16'b0, damping_amount_q};
			dfe_pkg::REG_DISTANCE: prdata = {19'b0, echo_distance_q};
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		fb    = (feedback_gain_q > FB_MAX) ? FB_MAX : feedback_gain_q;
		coeff = ONE_Q - ((damping_amount_q > ONE_Q) ? ONE_Q : damping_amount_q);
		if (echo_distance_q == '0) begin
			tap_dist = SW'(1);
		end else if ({19'b0, echo_distance_q} > 32'(LINE_DEPTH)) begin
			tap_dist = LEN_W;
		end else begin
			tap_dist = SW'(echo_distance_q);
		end
		rd_sum  = {2'b0, pos_q} + LEN_W - tap_dist;
		rd_addr = (rd_sum >= LEN_W) ? AW'(rd_sum - LEN_W) : AW'(rd_sum);
	end

	always_comb begin
		delayed = $signed({1'b0, rdata_q}) - MID_S;
		out_sum = $signed({2'b0, prior_q}) + 18'(delayed);
		if (out_sum < 0) begin
			out_sat = '0;
		end else if (out_sum > 18'sd65535) begin
			out_sat = '1;
		end else begin
			out_sat = out_sum[15:0];
		end
		prod_sh  = prod_q >>> FRAC_BITS;
		fb_in    = 20'($signed({1'b0, dry_q}) - MID_S) + prod_sh[19:0];
		filt_sum = 22'(filt_q) + prod_sh[21:0];
		if (filt_sum > 22'(dfe_pkg::FILT_MAX)) begin
			filt_new = dfe_pkg::FILT_MAX;
		end else if (filt_sum < 22'(dfe_pkg::FILT_MIN)) begin
			filt_new = dfe_pkg::FILT_MIN;
		end else begin
			filt_new = filt_sum[17:0];
		end
		line_sum = 22'(filt_new) + MID_X;
		if (line_sum < 0) begin
			line_val = '0;
		end else if (line_sum > 22'sd65535) begin
			line_val = '1;
		end else begin
			line_val = line_sum[15:0];
		end
	end

	// shared multiplier operands
	always_comb begin
		if (state_q == dfe_pkg::ST_MUL2) begin
			mul_a = diff_q;
			mul_b = $signed({1'b0, coeff});
		end else begin
			mul_a = 21'(delayed);
			mul_b = $signed({2'b0, fb});
		end
	end

	always_comb begin
		mem_we = (state_q == dfe_pkg::ST_CLEAR) || (state_q == dfe_pkg::ST_WR);
		mem_wa = (state_q == dfe_pkg::ST_CLEAR) ? clr_q : pos_q;
		mem_wd = (state_q == dfe_pkg::ST_CLEAR) ? dfe_pkg::SMP_W'(MID_LEVEL) : line_val;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (accept) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dry_q   <= dry_sample;
			prior_q <= prior_output;
		end
		if (state_q == dfe_pkg::ST_MUL1 || state_q == dfe_pkg::ST_MUL2) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == dfe_pkg::ST_SUB) begin
			diff_q <= 21'(fb_in) - 21'(filt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_gain_q  <= '0;
			damping_amount_q <= '0;
			echo_distance_q  <= dfe_pkg::DIST_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				dfe_pkg::REG_FEEDBACK: feedback_gain_q  <= pwdata[dfe_pkg::FB_W-1:0];
				dfe_pkg::REG_DAMPING:  damping_amount_q <= pwdata[dfe_pkg::DAMP_W-1:0];
				dfe_pkg::REG_DISTANCE: echo_distance_q  <= pwdata[dfe_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfe_pkg::ST_CLEAR;
			clr_q       <= '0;
			pos_q       <= '0;
			filt_q      <= '0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && !done_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				dfe_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == POS_LAST) begin
						state_q <= dfe_pkg::ST_IDLE;
					end
				end
				dfe_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= (fb == '0) ? dfe_pkg::ST_DONE : dfe_pkg::ST_MUL1;
					end
				end
				dfe_pkg::ST_MUL1: begin
					state_q <= dfe_pkg::ST_SUB;
				end
				dfe_pkg::ST_SUB: begin
					state_q <= dfe_pkg::ST_MUL2;
				end
				dfe_pkg::ST_MUL2: begin
					state_q <= dfe_pkg::ST_WR;
				end
				dfe_pkg::ST_WR: begin
					filt_q  <= filt_new;
					pos_q   <= (pos_q == POS_LAST) ? '0 : pos_q + AW'(1);
					state_q <= dfe_pkg::ST_DONE;
				end
				dfe_pkg::ST_DONE: begin
					if (done_go) begin
						result_q    <= (fb == '0) ? prior_q : out_sat;
						out_valid_q <= 1'b1;
						state_q     <= dfe_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= dfe_pkg::ST_IDLE;
				end
			endcase
		end
	end

	a_wr_only_clear_or_wr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == dfe_pkg::ST_CLEAR || state_q == dfe_pkg::ST_WR))
		else $error("line written outside clear or write step");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (32'(rd_addr) < 32'(LINE_DEPTH)))
		else $error("read tap beyond line");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < 32'(LINE_DEPTH))
		else $error("write position beyond line");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == dfe_pkg::ST_DONE))
		else $error("result loaded outside final step");

	a_bypass_keeps_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fb == '0) |=> $stable(pos_q) && $stable(filt_q))
		else $error("state moved with feedback zero");

endmodule
